>>> design/otp_uri_pkg.sv
// Package for the otpauth URI field parser: word types, result codes and
// the fixed match strings. No dependencies.

package otp_uri_pkg;

  // Limits on the label and secret lengths
  localparam int unsigned LabelMax  = 16;
  localparam int unsigned SecretMax = 128;

  // Fixed text lengths
  localparam int unsigned PrefixLen = 15;
  localparam int unsigned SearchLen = 8;

  // Special bytes
  localparam logic [7:0] CharPercent  = 8'h25;
  localparam logic [7:0] CharAmp      = 8'h26;
  localparam logic [7:0] CharQuestion = 8'h3f;
  localparam logic [7:0] CharTwo      = 8'h32;
  localparam logic [7:0] CharZero     = 8'h30;

  // Register reset values
  localparam logic [4:0] LabelLimitRst  = 5'd16;
  localparam logic [7:0] SecretLimitRst = 8'd128;
  localparam logic [7:0] SpaceCodeRst   = 8'h08;

  // Register indexes (paddr[3:2])
  typedef enum logic [1:0] {
    REG_LABEL_LIMIT  = 2'd0,
    REG_SECRET_LIMIT = 2'd1,
    REG_SPACE_CODE   = 2'd2
  } reg_idx_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_LABEL  = 2'd0,
    KIND_SECRET = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  // Final status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_PREFIX = 2'd1,
    ST_BAD_ESCAPE = 2'd2,
    ST_NO_SECRET  = 2'd3
  } status_e;

  // Parser phases, one-hot
  typedef enum logic [5:0] {
    PH_PREFIX = 6'b000001,
    PH_LABEL  = 6'b000010,
    PH_SEARCH = 6'b000100,
    PH_SECRET = 6'b001000,
    PH_DONE   = 6'b010000,
    PH_ERROR  = 6'b100000
  } phase_e;

  // Input word
  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_uri;
  } in_word_t;

  // Output word
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_value;
    logic [1:0] status;
    logic       last;
  } out_word_t;

  // "otpauth://totp/"
  function automatic logic [7:0] prefix_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h6f; // o
      4'd1:    c = 8'h74; // t
      4'd2:    c = 8'h70; // p
      4'd3:    c = 8'h61; // a
      4'd4:    c = 8'h75; // u
      4'd5:    c = 8'h74; // t
      4'd6:    c = 8'h68; // h
      4'd7:    c = 8'h3a; // :
      4'd8:    c = 8'h2f; // /
      4'd9:    c = 8'h2f; // /
      4'd10:   c = 8'h74; // t
      4'd11:   c = 8'h6f; // o
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h70; // p
      4'd14:   c = 8'h2f; // /
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "?secret="
  function automatic logic [7:0] search_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h3f; // ?
      3'd1:    c = 8'h73; // s
      3'd2:    c = 8'h65; // e
      3'd3:    c = 8'h63; // c
      3'd4:    c = 8'h72; // r
      3'd5:    c = 8'h65; // e
      3'd6:    c = 8'h74; // t
      default: c = 8'h3d; // =
    endcase
    return c;
  endfunction

endpackage

>>> design/otp_uri_field_parser.sv
// Streaming otpauth URI parser: prefix check, label and secret extraction.
// Depends on otp_uri_pkg.
//
// A word's results are in the output queue in the cycle after it is accepted.
// Throughput: one byte per cycle while the output is not stalled and each byte
// yields at most one result; the last byte (byte result plus status) can stall.
// Input stall is raised when two or more results wait in the 3-entry queue.
// Reset: parser returns to the prefix phase, queue empties, registers take
// their reset values (label limit 16, secret limit 128, space code 8).

module otp_uri_field_parser import otp_uri_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_word_i,
  // Result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_word_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers
  logic [4:0] label_limit_q;
  logic [7:0] secret_limit_q;
  logic [7:0] space_code_q;
  logic       cfg_wr;
  reg_idx_e   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      label_limit_q  <= LabelLimitRst;
      secret_limit_q <= SecretLimitRst;
      space_code_q   <= SpaceCodeRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LABEL_LIMIT:  label_limit_q  <= pwdata[4:0];
        REG_SECRET_LIMIT: secret_limit_q <= pwdata[7:0];
        REG_SPACE_CODE:   space_code_q   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_LABEL_LIMIT:  prdata = {27'd0, label_limit_q};
      REG_SECRET_LIMIT: prdata = {24'd0, secret_limit_q};
      REG_SPACE_CODE:   prdata = {24'd0, space_code_q};
      default:          prdata = '0;
    endcase
  end

  // Effective limits, clamped to the maximums
  logic [4:0] label_lim;
  logic [7:0] secret_lim;
  assign label_lim  = (label_limit_q < 5'(LabelMax)) ? label_limit_q : 5'(LabelMax);
  assign secret_lim = (secret_limit_q < 8'(SecretMax)) ? secret_limit_q : 8'(SecretMax);

  // Parser state
  phase_e     phase_q, phase_d;
  logic [3:0] prefix_idx_q, prefix_idx_d;
  logic [1:0] esc_step_q, esc_step_d;
  logic [4:0] label_cnt_q, label_cnt_d;
  logic [3:0] match_cnt_q, match_cnt_d;
  logic [7:0] secret_cnt_q, secret_cnt_d;
  status_e    err_q, err_d;

  // Output queue
  out_word_t  queue_q [3];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  logic       in_acc, out_pop;
  logic [7:0] b;
  logic       srch_hit;
  logic       emit_byte;
  out_word_t  byte_word, stat_word;
  status_e    stat;

  assign in_stall_o  = (count_q >= 2'd2);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (count_q != 2'd0);
  assign out_pop     = out_valid_o && !out_stall_i;
  assign out_word_o  = queue_q[rd_ptr_q];
  assign b           = in_word_i.byte_value;

  // Naive "?secret=" matcher step
  assign srch_hit = (match_cnt_q < 4'(SearchLen)) && (b == search_char(match_cnt_q[2:0]));

  // Per-byte parse step
  always_comb begin
    phase_d      = phase_q;
    prefix_idx_d = prefix_idx_q;
    esc_step_d   = esc_step_q;
    label_cnt_d  = label_cnt_q;
    match_cnt_d  = match_cnt_q;
    secret_cnt_d = secret_cnt_q;
    err_d        = err_q;
    emit_byte    = 1'b0;
    byte_word    = '{kind: KIND_LABEL, char_value: b, status: ST_OK, last: 1'b0};
    stat         = ST_OK;

    unique case (phase_q)
      PH_PREFIX: begin
        if (prefix_idx_q < 4'(PrefixLen) && b == prefix_char(prefix_idx_q)) begin
          prefix_idx_d = prefix_idx_q + 4'd1;
          if (prefix_idx_d == 4'(PrefixLen)) phase_d = PH_LABEL;
        end else begin
          err_d   = ST_BAD_PREFIX;
          phase_d = PH_ERROR;
        end
      end
      PH_LABEL: begin
        if (esc_step_q == 2'd1) begin
          if (b == CharTwo) begin
            esc_step_d = 2'd2;
          end else begin
            err_d   = ST_BAD_ESCAPE;
            phase_d = PH_ERROR;
          end
        end else if (esc_step_q == 2'd2) begin
          if (b == CharZero) begin
            emit_byte            = 1'b1;
            byte_word.char_value = space_code_q;
            label_cnt_d          = label_cnt_q + 5'd1;
            esc_step_d           = 2'd0;
          end else begin
            err_d   = ST_BAD_ESCAPE;
            phase_d = PH_ERROR;
          end
        end else if (label_cnt_q >= label_lim || b == CharQuestion) begin
          // Byte starts the search
          phase_d = PH_SEARCH;
          if (srch_hit) begin
            match_cnt_d = match_cnt_q + 4'd1;
            if (match_cnt_d == 4'(SearchLen)) phase_d = PH_SECRET;
          end else begin
            match_cnt_d = '0;
          end
        end else if (b == CharPercent) begin
          esc_step_d = 2'd1;
        end else begin
          emit_byte   = 1'b1;
          label_cnt_d = label_cnt_q + 5'd1;
        end
      end
      PH_SEARCH: begin
        if (srch_hit) begin
          match_cnt_d = match_cnt_q + 4'd1;
          if (match_cnt_d == 4'(SearchLen)) phase_d = PH_SECRET;
        end else begin
          match_cnt_d = '0;
        end
      end
      PH_SECRET: begin
        if (secret_cnt_q >= secret_lim || b == CharAmp) begin
          phase_d = PH_DONE;
        end else begin
          emit_byte      = 1'b1;
          byte_word.kind = KIND_SECRET;
          secret_cnt_d   = secret_cnt_q + 8'd1;
        end
      end
      PH_DONE, PH_ERROR: ;
      default: ;
    endcase

    // Final status from the updated state
    if (err_d != ST_OK)          stat = err_d;
    else if (phase_d == PH_PREFIX) stat = ST_BAD_PREFIX;
    else if (phase_d == PH_LABEL)
      stat = (esc_step_d != 2'd0) ? ST_BAD_ESCAPE : ST_NO_SECRET;
    else if (phase_d == PH_SEARCH) stat = ST_NO_SECRET;
    else                           stat = ST_OK;

    // End of URI returns the parser to its reset state
    if (in_word_i.end_of_uri) begin
      phase_d      = PH_PREFIX;
      prefix_idx_d = '0;
      esc_step_d   = '0;
      label_cnt_d  = '0;
      match_cnt_d  = '0;
      secret_cnt_d = '0;
      err_d        = ST_OK;
    end
  end

  assign stat_word = '{kind: KIND_STATUS, char_value: 8'd0, status: stat, last: 1'b1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_PREFIX;
      prefix_idx_q <= '0;
      esc_step_q   <= '0;
      label_cnt_q  <= '0;
      match_cnt_q  <= '0;
      secret_cnt_q <= '0;
      err_q        <= ST_OK;
    end else if (in_acc) begin
      phase_q      <= phase_d;
      prefix_idx_q <= prefix_idx_d;
      esc_step_q   <= esc_step_d;
      label_cnt_q  <= label_cnt_d;
      match_cnt_q  <= match_cnt_d;
      secret_cnt_q <= secret_cnt_d;
      err_q        <= err_d;
    end
  end

  // Queue pointer step, modulo three
  function automatic logic [1:0] ptr_inc(input logic [1:0] p);
    return (p == 2'd2) ? 2'd0 : p + 2'd1;
  endfunction

  logic       push_byte, push_stat;
  logic [1:0] stat_ptr;
  logic [1:0] push_cnt;

  assign push_byte = in_acc && emit_byte;
  assign push_stat = in_acc && in_word_i.end_of_uri;
  assign stat_ptr  = push_byte ? ptr_inc(wr_ptr_q) : wr_ptr_q;
  assign push_cnt  = {1'b0, push_byte} + {1'b0, push_stat};

  // Queue payload
  always_ff @(posedge clk_i) begin
    if (push_byte) queue_q[wr_ptr_q] <= byte_word;
    if (push_stat) queue_q[stat_ptr] <= stat_word;
  end

  // Queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_stat)      wr_ptr_q <= ptr_inc(stat_ptr);
      else if (push_byte) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (out_pop) rd_ptr_q <= ptr_inc(rd_ptr_q);
      count_q <= count_q + push_cnt - {1'b0, out_pop};
    end
  end

endmodule
